>>> rtl/handheld_io_register_block_top_macros.svh
// assertion macros for the handheld io register block
`ifndef HANDHELD_IO_REGISTER_BLOCK_TOP_MACROS_SVH
`define HANDHELD_IO_REGISTER_BLOCK_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define HIRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define HIRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hirb_pkg.sv
// ----------------------------------------------------------------------------
// hirb_pkg
// types and constants shared by the handheld io register block
// ----------------------------------------------------------------------------
package hirb_pkg;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_KEYPAD = 2'd2,
        KIND_LCDACK = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REGION_NOR   = 3'd0,
        REGION_VOL0  = 3'd1,
        REGION_VOL1  = 3'd2,
        REGION_VOL2  = 3'd3,
        REGION_NONE  = 3'd4
    } region_t;

    // io register addresses with side effects
    localparam logic [5:0] ADDR_BANK    = 6'h00;
    localparam logic [5:0] ADDR_CLKCTL  = 6'h05;
    localparam logic [5:0] ADDR_LCD     = 6'h06;
    localparam logic [5:0] ADDR_KEYOUT  = 6'h08;
    localparam logic [5:0] ADDR_SCAN    = 6'h09;
    localparam logic [5:0] ADDR_ROMSEL  = 6'h0A;
    localparam logic [5:0] ADDR_KEYSTAT = 6'h0B;
    localparam logic [5:0] ADDR_LCDHI   = 6'h0C;
    localparam logic [5:0] ADDR_VOLUME  = 6'h0D;
    localparam logic [5:0] ADDR_KEYMASK = 6'h15;
    localparam logic [5:0] ADDR_WAVECTL = 6'h20;
    localparam logic [5:0] ADDR_WAVEDAT = 6'h22;
    localparam logic [5:0] ADDR_WAVECMD = 6'h23;
    localparam logic [5:0] ADDR_CLKSEC  = 6'h3B;
    localparam logic [5:0] ADDR_CLKSTAT = 6'h3D;
    localparam logic [5:0] ADDR_CLKIDX  = 6'h3E;
    localparam logic [5:0] ADDR_CLKDAT  = 6'h3F;

    // command and marker values
    localparam logic [7:0] WAVE_STORE    = 8'hC2;
    localparam logic [7:0] WAVE_STORE_INC = 8'hC4;
    localparam logic [7:0] WAVE_END      = 8'h80;
    localparam logic [7:0] WAVE_START_A  = 8'h80;
    localparam logic [7:0] WAVE_START_B  = 8'h40;
    localparam logic [7:0] CLK_STAT_VAL  = 8'hF8;
    localparam logic [7:0] KEY_ALL_ROWS  = 8'h7F;
    localparam logic [7:0] KEY_ROW7_ON   = 8'hFE;

    // window mapping: volume, slot, low page
    typedef struct packed {
        logic [1:0] vol;
        logic [3:0] slot;
        logic       page;
    } window_t;

    typedef struct packed {
        region_t    region;
        logic [7:0] bank;
    } bank_t;

    // bank region from bank number and volume register
    function automatic region_t bank_region(input logic [7:0] b, input logic [7:0] v);
        region_t r;
        if (b < 8'h20)
            r = REGION_NOR;
        else if (b[7])
            r = v[0] ? REGION_VOL1 : (v[1] ? REGION_VOL2 : REGION_VOL0);
        else
            r = REGION_NONE;
        return r;
    endfunction

endpackage

>>> rtl/hirb_keypad.sv
// ----------------------------------------------------------------------------
// hirb_keypad
// keypad row store and scan decode for a write to the scan register
// ----------------------------------------------------------------------------
module hirb_keypad (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       row_we,
    input  logic [5:0] row_addr,
    input  logic [7:0] row_data,
    input  logic [7:0] scan,
    input  logic [7:0] key_mask,
    output logic       out_we,
    output logic [7:0] out_val,
    output logic       stat_set,
    output logic       stat_clr
);
    import hirb_pkg::*;

    logic [7:0] rows_reg [8];
    logic [7:0] all_rows;

    // row store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                rows_reg[i] <= '0;
        end
        else if (row_we && row_addr[5:3] == 3'd0)
        begin
            rows_reg[row_addr[2:0]] <= row_data;
        end
    end

    // scan decode
    always_comb
    begin
        all_rows = '0;
        for (int i = 0; i < 8; i++)
            all_rows = all_rows | rows_reg[i];
        out_we   = 1'b0;
        out_val  = all_rows;
        stat_set = 1'b0;
        stat_clr = 1'b0;
        if ($onehot(scan))
        begin
            out_we = 1'b1;
            for (int i = 0; i < 8; i++)
                if (scan[i])
                    out_val = rows_reg[i];
        end
        else if (scan == 8'h00)
        begin
            stat_set = (rows_reg[7] != KEY_ROW7_ON);
            stat_clr = (rows_reg[7] == KEY_ROW7_ON);
        end
        else if (scan == KEY_ALL_ROWS && key_mask == KEY_ALL_ROWS)
        begin
            out_we = 1'b1;
        end
    end
endmodule

>>> rtl/handheld_io_register_block_top.sv
// result: an accepted item's result is in the output register in the next cycle
// throughput: one item per cycle; a skid-free output register with stall on m_axis_tready
// all side effects of an item complete in the cycle it is accepted
// reset: side-effect registers, keypad rows and latches clear; io and clock stores
// read as zero until written through valid flags cleared at reset; wave buffer not cleared
// ----------------------------------------------------------------------------
// handheld_io_register_block_top
// io register file with bank/window latches, clock store, keypad and wave buffer
// ----------------------------------------------------------------------------
`include "handheld_io_register_block_top_macros.svh"

module handheld_io_register_block_top #(
    parameter int CLOCK_BYTES = 80,
    parameter int WAVE_BYTES  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: address[5:0], data[13:6], zero [15:14]
    input  logic [15:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: read_data[7:0], bank_region[10:8], bank_number[18:11],
    // low_window_page[19], bbs_volume[21:20], bbs_slot[25:22], sleeping[26],
    // lcd_start[40:27], clock_flag_bits[43:41], wave_count[49:44],
    // wave_collecting[50], zero [55:51]
    output logic [55:0] m_axis_tdata
);
    import hirb_pkg::*;

    localparam int WIW = $clog2(WAVE_BYTES + 1);
    localparam int WAW = $clog2(WAVE_BYTES);
    localparam int CAW = $clog2(CLOCK_BYTES);

    // source of the read byte in the result
    localparam logic [1:0] RD_DIRECT = 2'd0;
    localparam logic [1:0] RD_IO     = 2'd1;
    localparam logic [1:0] RD_CLOCK  = 2'd2;

    // plain io storage, a full copy of every write
    logic [7:0]             io_mem [64];
    logic [63:0]            io_vld_reg;
    logic [7:0]             io_rd_reg;
    logic                   io_rdv_reg;
    // clock store, with the two bytes that are read at fixed places
    logic [7:0]             clk_mem [CLOCK_BYTES];
    logic [CLOCK_BYTES-1:0] clk_vld_reg;
    logic [7:0]             clk_rd_reg;
    logic                   clk_rdv_reg;
    logic [7:0]             cprot_reg;
    logic [7:0]             csec_reg;
    // io registers with side effects or fixed readers
    logic [7:0]             iobank_reg;
    logic [7:0]             clkctl_reg;
    logic [7:0]             keyout_reg;
    logic [7:0]             scan_reg;
    logic [7:0]             romsel_reg;
    logic [7:0]             keystat_reg;
    logic [7:0]             lcdhi_reg;
    logic [7:0]             volume_reg;
    logic [7:0]             keymask_reg;
    logic [7:0]             wavectl_reg;
    logic [7:0]             wavedat_reg;
    logic [7:0]             clkstat_reg;
    logic [7:0]             clkidx_reg;

    logic [7:0]     wave_mem [WAVE_BYTES];
    logic [WIW-1:0] widx_reg;
    logic           wflag_reg;
    logic           sleep_reg;
    logic [13:0]    lcd_reg;
    logic [2:0]     cflags_reg;
    bank_t          bank_reg;
    window_t        win_reg;
    logic [55:0]    out_reg;
    logic           ovalid_reg;
    logic [1:0]     rsel_reg;

    logic           accept;
    kind_t          kind;
    logic [5:0]     addr;
    logic [7:0]     wdata;
    logic           wr;
    logic [7:0]     old;
    logic [7:0]     rd;
    logic [1:0]     rd_src;
    logic [7:0]     rd_out;
    logic [7:0]     idx;
    logic           crd_ok;
    logic [CAW-1:0] crd_addr;
    logic [10:0]    cw;
    logic [CAW-1:0] cidx_wrap;
    logic           cwe;
    logic [CAW-1:0] caddr;
    logic [7:0]     cval;
    logic           kp_we, kp_set, kp_clr;
    logic [7:0]     kp_val;
    logic [7:0]     vol_n, bnk_n, sel_n;
    logic [WIW-1:0] widx_next;
    logic           wflag_next, sleep_next;
    logic [13:0]    lcd_next;
    logic [2:0]     cflags_next;
    bank_t          bank_next;
    window_t        win_next;
    logic           wave_we;
    logic [1:0]     vsel;

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign kind     = kind_t'(s_axis_tuser);
    assign addr     = s_axis_tdata[5:0];
    assign wdata    = s_axis_tdata[13:6];
    assign wr       = accept && kind == KIND_WRITE;
    assign idx      = clkidx_reg;
    assign crd_addr = CAW'(idx);

    // clock index wrapped into the store by compare and subtract
    always_comb
    begin
        cw = {3'b000, idx};
        for (int k = 3; k >= 0; k--)
            if (cw >= 11'(CLOCK_BYTES << k))
                cw = cw - 11'(CLOCK_BYTES << k);
        cidx_wrap = CAW'(cw);
    end

    hirb_keypad u_keypad (
        .clk      (clk),
        .rst_n    (rst_n),
        .row_we   (accept && kind == KIND_KEYPAD),
        .row_addr (addr),
        .row_data (wdata),
        .scan     (wdata),
        .key_mask (keymask_reg),
        .out_we   (kp_we),
        .out_val  (kp_val),
        .stat_set (kp_set),
        .stat_clr (kp_clr)
    );

    // previous value of registers whose write compares
    always_comb
    begin
        case (addr)
            ADDR_BANK:   old = iobank_reg;
            ADDR_CLKCTL: old = clkctl_reg;
            ADDR_ROMSEL: old = romsel_reg;
            ADDR_VOLUME: old = volume_reg;
            default:     old = 8'h00;
        endcase
    end

    // read path, memories answer in the next cycle
    always_comb
    begin
        crd_ok = 32'(idx) < CLOCK_BYTES;
        rd     = 8'h00;
        rd_src = RD_DIRECT;
        if (kind == KIND_READ)
        begin
            case (addr)
                ADDR_BANK:    rd = iobank_reg;
                ADDR_CLKCTL:  rd = clkctl_reg;
                ADDR_KEYOUT:  rd = keyout_reg;
                ADDR_SCAN:    rd = scan_reg;
                ADDR_ROMSEL:  rd = romsel_reg;
                ADDR_KEYSTAT: rd = keystat_reg;
                ADDR_LCDHI:   rd = lcdhi_reg;
                ADDR_VOLUME:  rd = volume_reg;
                ADDR_KEYMASK: rd = keymask_reg;
                ADDR_WAVECTL: rd = wavectl_reg;
                ADDR_WAVEDAT: rd = wavedat_reg;
                ADDR_CLKSTAT: rd = clkstat_reg;
                ADDR_CLKIDX:  rd = clkidx_reg;
                ADDR_CLKSEC:
                    if (clkstat_reg[1:0] == 2'b00)
                        rd = csec_reg & 8'hFE;
                    else
                        rd_src = RD_IO;
                ADDR_CLKDAT:
                    if (crd_ok)
                        rd_src = RD_CLOCK;
                default:      rd_src = RD_IO;
            endcase
        end
    end

    // clock store write decode
    always_comb
    begin
        cwe   = 1'b0;
        caddr = cidx_wrap;
        cval  = wdata;
        if (wr && addr == ADDR_CLKDAT)
        begin
            if (idx >= 8'h07)
            begin
                cwe = 1'b1;
                if (idx == 8'h0B)
                    cval = {wdata[7], cprot_reg[6:0]};
            end
            else
            begin
                cwe = !cprot_reg[7];
            end
        end
    end

    // mapping values after this write
    always_comb
    begin
        vol_n = (wr && addr == ADDR_VOLUME) ? wdata : volume_reg;
        bnk_n = (wr && addr == ADDR_BANK) ? wdata : iobank_reg;
        sel_n = romsel_reg;
        vsel  = (vol_n[1:0] == 2'd1) ? 2'd1 : ((vol_n[1:0] == 2'd3) ? 2'd2 : 2'd0);
    end

    // status and latch update
    always_comb
    begin
        widx_next   = widx_reg;
        wflag_next  = wflag_reg;
        sleep_next  = sleep_reg;
        lcd_next    = lcd_reg;
        cflags_next = cflags_reg;
        bank_next   = bank_reg;
        win_next    = win_reg;
        wave_we     = 1'b0;
        if (accept && kind == KIND_LCDACK)
            lcd_next = '0;
        if (wr && wdata != old)
        begin
            case (addr)
                ADDR_BANK:
                begin
                    bank_next.region = bank_region(bnk_n, vol_n);
                    bank_next.bank   = bnk_n;
                end
                ADDR_ROMSEL:  win_next.slot = wdata[3:0];
                ADDR_VOLUME:
                begin
                    win_next.vol     = vsel;
                    win_next.slot    = sel_n[3:0];
                    win_next.page    = sel_n[2];
                    bank_next.region = bank_region(bnk_n, vol_n);
                    bank_next.bank   = bnk_n;
                end
                default: ;
            endcase
        end
        if (wr)
        begin
            case (addr)
                ADDR_CLKCTL:
                    if (old[3] != wdata[3])
                        sleep_next = !wdata[3];
                ADDR_LCD:
                    if (lcd_reg == '0)
                        lcd_next = {lcdhi_reg[1:0], wdata, 4'h0};
                ADDR_WAVECTL:
                    if (wdata == WAVE_START_A || wdata == WAVE_START_B)
                    begin
                        wflag_next = 1'b1;
                        widx_next  = '0;
                    end
                ADDR_WAVECMD:
                    if (wdata == WAVE_STORE || wdata == WAVE_STORE_INC)
                    begin
                        if (32'(widx_reg) < WAVE_BYTES)
                        begin
                            wave_we = 1'b1;
                            if (wdata == WAVE_STORE_INC)
                                widx_next = widx_reg + 1'b1;
                        end
                    end
                    else if (wdata == WAVE_END)
                    begin
                        wflag_next = 1'b0;
                        widx_next  = '0;
                    end
                ADDR_CLKDAT:
                    if (idx == 8'h0B || idx == 8'h0A)
                        cflags_next = cflags_reg | wdata[2:0];
                default: ;
            endcase
        end
    end

    // io registers with side effects
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iobank_reg  <= '0;
            clkctl_reg  <= '0;
            keyout_reg  <= '0;
            scan_reg    <= '0;
            romsel_reg  <= '0;
            keystat_reg <= '0;
            lcdhi_reg   <= '0;
            volume_reg  <= '0;
            keymask_reg <= '0;
            wavectl_reg <= '0;
            wavedat_reg <= '0;
            clkstat_reg <= '0;
            clkidx_reg  <= '0;
        end
        else if (wr)
        begin
            case (addr)
                ADDR_BANK:    iobank_reg <= wdata;
                ADDR_CLKCTL:  clkctl_reg <= wdata;
                ADDR_LCD:     scan_reg <= scan_reg & 8'hFE;
                ADDR_KEYOUT:
                begin
                    keyout_reg  <= wdata;
                    keystat_reg <= keystat_reg & 8'hFE;
                end
                ADDR_SCAN:
                begin
                    scan_reg <= wdata;
                    if (kp_we)
                        keyout_reg <= kp_val;
                    if (kp_set)
                        keystat_reg <= keystat_reg | 8'h01;
                    else if (kp_clr)
                        keystat_reg <= keystat_reg & 8'hFE;
                end
                ADDR_ROMSEL:  romsel_reg <= wdata;
                ADDR_KEYSTAT: keystat_reg <= wdata;
                ADDR_LCDHI:   lcdhi_reg <= wdata;
                ADDR_VOLUME:  volume_reg <= wdata;
                ADDR_KEYMASK: keymask_reg <= wdata;
                ADDR_WAVECTL:
                    if (wdata == WAVE_START_A || wdata == WAVE_START_B)
                        wavectl_reg <= 8'h00;
                    else
                        wavectl_reg <= wdata;
                ADDR_WAVEDAT: wavedat_reg <= wdata;
                ADDR_WAVECMD:
                    if (wdata == WAVE_END)
                        wavectl_reg <= WAVE_END;
                ADDR_CLKSTAT: clkstat_reg <= wdata;
                ADDR_CLKIDX:  clkidx_reg <= wdata;
                ADDR_CLKDAT:
                    if (idx == 8'h0B)
                        clkstat_reg <= CLK_STAT_VAL;
                default: ;
            endcase
        end
    end

    // plain io storage
    always_ff @(posedge clk)
    begin
        if (wr)
            io_mem[addr] <= wdata;
        if (accept)
            io_rd_reg <= io_mem[addr];
    end

    // io written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_vld_reg <= '0;
            io_rdv_reg <= 1'b0;
        end
        else
        begin
            if (wr)
                io_vld_reg[addr] <= 1'b1;
            if (accept)
                io_rdv_reg <= io_vld_reg[addr];
        end
    end

    // clock store
    always_ff @(posedge clk)
    begin
        if (cwe)
            clk_mem[caddr] <= cval;
        if (accept)
            clk_rd_reg <= clk_mem[crd_addr];
    end

    // clock written flags and fixed-place clock bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_vld_reg <= '0;
            clk_rdv_reg <= 1'b0;
            cprot_reg   <= '0;
            csec_reg    <= '0;
        end
        else
        begin
            if (cwe)
            begin
                clk_vld_reg[caddr] <= 1'b1;
                if (32'(caddr) == 32'h0B)
                    cprot_reg <= cval;
                if (32'(caddr) == 32'(ADDR_CLKSEC))
                    csec_reg <= cval;
            end
            if (accept)
                clk_rdv_reg <= clk_vld_reg[crd_addr];
        end
    end

    // wave buffer, never read out
    always_ff @(posedge clk)
    begin
        if (wave_we)
            wave_mem[widx_reg[WAW-1:0]] <= wavedat_reg;
    end

    // status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg   <= '0;
            wflag_reg  <= 1'b0;
            sleep_reg  <= 1'b0;
            lcd_reg    <= '0;
            cflags_reg <= '0;
            bank_reg   <= '{region: REGION_NOR, bank: 8'h00};
            win_reg    <= '0;
        end
        else
        begin
            widx_reg   <= widx_next;
            wflag_reg  <= wflag_next;
            sleep_reg  <= sleep_next;
            lcd_reg    <= lcd_next;
            cflags_reg <= cflags_next;
            bank_reg   <= bank_next;
            win_reg    <= win_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            rsel_reg   <= RD_DIRECT;
        end
        else
        begin
            if (s_axis_tready)
                ovalid_reg <= s_axis_tvalid;
            if (accept)
                rsel_reg <= rd_src;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= {5'd0, wflag_next, 6'(widx_next), cflags_next, lcd_next,
                        sleep_next, win_next.slot, win_next.vol, win_next.page,
                        bank_next.bank, 3'(bank_next.region), rd};
    end

    // read byte from the register or from a memory
    always_comb
    begin
        case (rsel_reg)
            RD_IO:    rd_out = io_rdv_reg ? io_rd_reg : 8'h00;
            RD_CLOCK: rd_out = clk_rdv_reg ? clk_rd_reg : 8'h00;
            default:  rd_out = out_reg[7:0];
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {out_reg[55:8], rd_out};

    `HIRB_ASSERT_NEXT(a_out_valid, clk, rst_n, accept, m_axis_tvalid,
        "accepted item gave no result")
    `HIRB_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `HIRB_ASSERT_IMP(a_widx, clk, rst_n, 1'b1, 32'(widx_reg) <= WAVE_BYTES,
        "wave index past buffer")
    `HIRB_ASSERT_IMP(a_lcd_low, clk, rst_n, 1'b1, lcd_reg[3:0] == 4'h0,
        "lcd latch low nibble set")
endmodule
